// ===== hw/rtl/q4d_pkg.sv =====
// ----------------------------------------------------------------------------
// Q4 dequantizer package
// Shared types and constants for the block dequantizer.
// ----------------------------------------------------------------------------
package q4d_pkg;

    localparam int unsigned BEATS       = 8;
    localparam int unsigned LANES       = 4;
    localparam int unsigned CODE_OFFSET = 8;
    localparam logic [3:0]  NIBBLE_MASK = 4'hF;
    localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;

    typedef logic [2:0]  beat_t;
    typedef logic [31:0] fp32_t;
    typedef logic [15:0] fp16_t;

    typedef struct packed {
        logic  valid;
        beat_t beat;
        logic  row_end;
    } beat_ctrl_t;

endpackage

// ===== hw/rtl/q4d_lane.sv =====
// ----------------------------------------------------------------------------
// Q4 dequantizer lane
// Scales one 4-bit code by a binary16 scale into an exact binary32 value.
// ----------------------------------------------------------------------------
module q4d_lane
(
    input  q4d_pkg::fp16_t scale,
    input  logic [3:0]     code,
    output q4d_pkg::fp32_t value
);
    import q4d_pkg::*;

    logic       sgn;
    logic [4:0] e;
    logic [9:0] m;
    logic       neg;
    logic [3:0] mag;
    logic [10:0] sig_in;
    logic [14:0] sig;
    logic [3:0]  p;
    logic [7:0]  expo;
    logic [22:0] frac;
    logic [37:0] shifted;

    always_comb
    begin
        sgn    = scale[15];
        e      = scale[14:10];
        m      = scale[9:0];
        neg    = (code < 4'(CODE_OFFSET));
        mag    = neg ? (4'(CODE_OFFSET) - code) : (code - 4'(CODE_OFFSET));
        sig_in = (e == 5'd0) ? {1'b0, m} : {1'b1, m};
        sig    = 15'(sig_in) * 15'(mag);
        p      = 4'd0;
        for (int i = 1; i < 15; i++)
        begin
            if (sig[i])
            begin
                p = 4'(i);
            end
        end
        // Exponent: p + k + 127, k = -24 for subnormal, e - 25 otherwise.
        if (e == 5'd0)
        begin
            expo = 8'(p) + 8'd103;
        end
        else
        begin
            expo = 8'(p) + 8'(e) + 8'd102;
        end
        shifted = 38'(sig) << (5'd23 - 5'(p));
        frac    = shifted[22:0];
        if (e == 5'h1F)
        begin
            if (m != 10'd0)
            begin
                // The payload's top bit lands on the quiet bit, which is set anyway.
                value = {sgn, 8'hFF, 1'b1, m[8:0], 13'd0};
            end
            else if (mag == 4'd0)
            begin
                value = DEFAULT_NAN;
            end
            else
            begin
                value = {sgn ^ neg, 8'hFF, 23'd0};
            end
        end
        else if (sig == 15'd0)
        begin
            value = {sgn ^ neg, 31'd0};
        end
        else
        begin
            value = {sgn ^ neg, expo, frac};
        end
    end

endmodule

// ===== hw/rtl/q4d_sequencer.sv =====
// ----------------------------------------------------------------------------
// Q4 dequantizer sequencer
// Holds the accepted block and steps through its eight beats.
// ----------------------------------------------------------------------------
module q4d_sequencer
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  q4d_pkg::fp16_t       scale_bits,
    input  logic [63:0]          quants_first_half,
    input  logic [63:0]          quants_second_half,
    input  logic                 row_end,
    output logic                 busy,
    output q4d_pkg::beat_ctrl_t  ctrl,
    output q4d_pkg::fp16_t       scale,
    output logic [15:0]          codes
);
    import q4d_pkg::*;

    logic        active_reg, active_next;
    beat_t       beat_reg, beat_next;
    logic        row_end_reg, row_end_next;
    fp16_t       scale_reg;
    logic [63:0] q0_reg, q1_reg;
    logic        take;

    assign take = start && !active_reg;
    assign busy = active_reg && (beat_reg != 3'(BEATS - 1));

    always_comb
    begin
        active_next  = active_reg;
        beat_next    = beat_reg;
        row_end_next = row_end_reg;
        if (take || (active_reg && beat_reg == 3'(BEATS - 1) && start))
        begin
            active_next  = 1'b1;
            beat_next    = 3'd0;
            row_end_next = row_end;
        end
        else if (active_reg)
        begin
            beat_next = beat_reg + 3'd1;
            if (beat_reg == 3'(BEATS - 1))
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            beat_reg    <= 3'd0;
            row_end_reg <= 1'b0;
        end
        else
        begin
            active_reg  <= active_next;
            beat_reg    <= beat_next;
            row_end_reg <= row_end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            scale_reg <= scale_bits;
            q0_reg    <= quants_first_half;
            q1_reg    <= quants_second_half;
        end
    end

    // Beats 0..3 take low nibbles, beats 4..7 high nibbles of the same bytes.
    always_comb
    begin
        logic [63:0] word;
        word = beat_reg[1] ? q1_reg : q0_reg;
        for (int j = 0; j < 4; j++)
        begin
            if (beat_reg[2])
            begin
                codes[4*j +: 4] = word[32*beat_reg[0] + 8*j + 4 +: 4] & NIBBLE_MASK;
            end
            else
            begin
                codes[4*j +: 4] = word[32*beat_reg[0] + 8*j +: 4] & NIBBLE_MASK;
            end
        end
    end

    assign ctrl.valid   = active_reg;
    assign ctrl.beat    = beat_reg;
    assign ctrl.row_end = row_end_reg;
    assign scale        = scale_reg;

endmodule

// ===== hw/rtl/q4_0_block_dequantizer_core.sv =====
// ----------------------------------------------------------------------------
// Q4_0 block dequantizer core
// Expands one 32-value 4-bit block into eight beats of four binary32 values.
// ----------------------------------------------------------------------------
// A block is taken on a rising edge with start high and busy low. The block
// is held in an input register; each following cycle one beat of four values
// is computed by four parallel lanes and registered into the result ports.
// A beat reaches the ports from the input register through the result
// registers, and beats follow one per cycle, strobed by valid. busy falls
// during the last beat, so a new block can be taken then and its beats
// follow without a gap; throughput is set by the single four-lane converter.
// block_done marks beat 7, and row_done marks beat 7 of a block flagged
// row_end. Results cannot be stalled; each is shown for exactly one cycle.
// Reset clears the beat sequencer and the result strobe; held data is left
// as is.
// ----------------------------------------------------------------------------
module q4_0_block_dequantizer_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] scale_bits,
    input  logic [63:0] quants_first_half,
    input  logic [63:0] quants_second_half,
    input  logic        row_end,
    output logic        valid,
    output logic [31:0] value_a,
    output logic [31:0] value_b,
    output logic [31:0] value_c,
    output logic [31:0] value_d,
    output logic [2:0]  beat,
    output logic        block_done,
    output logic        row_done
);
    import q4d_pkg::*;

    beat_ctrl_t  ctrl;
    fp16_t       scale;
    logic [15:0] codes;
    fp32_t       lane_value [LANES];
    logic        valid_reg;
    fp32_t       a_reg, b_reg, c_reg, d_reg;
    beat_t       beat_reg;
    logic        block_done_reg, row_done_reg;

    q4d_sequencer u_seq
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .scale_bits         (scale_bits),
        .quants_first_half  (quants_first_half),
        .quants_second_half (quants_second_half),
        .row_end            (row_end),
        .busy               (busy),
        .ctrl               (ctrl),
        .scale              (scale),
        .codes              (codes)
    );

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        q4d_lane u_lane
        (
            .scale (scale),
            .code  (codes[4*g +: 4]),
            .value (lane_value[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= ctrl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg          <= lane_value[0];
        b_reg          <= lane_value[1];
        c_reg          <= lane_value[2];
        d_reg          <= lane_value[3];
        beat_reg       <= ctrl.beat;
        block_done_reg <= (ctrl.beat == 3'(BEATS - 1));
        row_done_reg   <= (ctrl.beat == 3'(BEATS - 1)) && ctrl.row_end;
    end

    assign valid      = valid_reg;
    assign value_a    = a_reg;
    assign value_b    = b_reg;
    assign value_c    = c_reg;
    assign value_d    = d_reg;
    assign beat       = beat_reg;
    assign block_done = block_done_reg;
    assign row_done   = row_done_reg;

endmodule

// ===== hw/rtl/q4d_checker.sv =====
// ----------------------------------------------------------------------------
// Q4 dequantizer checker
// Port-level properties of the block dequantizer core.
// ----------------------------------------------------------------------------
module q4d_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       valid,
    input logic [2:0] beat,
    input logic       block_done,
    input logic       row_done
);
    a_beat_step: assert property (@(posedge clk) disable iff (!rst_n)
        valid && beat != 3'd7 |=> valid && beat == $past(beat) + 3'd1)
        else $error("beat sequence broken");

    a_done_beat: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> block_done == (beat == 3'd7))
        else $error("block_done not on last beat");

    a_row_done: assert property (@(posedge clk) disable iff (!rst_n)
        row_done |-> valid && block_done)
        else $error("row_done outside last beat");

    a_take_first: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##2 valid && beat == 3'd0)
        else $error("accepted block gave no first beat");

endmodule

bind q4_0_block_dequantizer_core q4d_checker u_q4d_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .valid      (valid),
    .beat       (beat),
    .block_done (block_done),
    .row_done   (row_done)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Q4_0 block dequantizer testbench
// Sends quantized blocks in random bursts, predicts the eight beats of four
// binary32 values per block and compares every result transfer with them.
// ----------------------------------------------------------------------------
module testbench;

    import q4d_pkg::*;

    typedef struct {
        fp32_t v [4];
        beat_t bt;
        logic  bdone;
        logic  rdone;
    } beat_exp_t;

    typedef struct {
        fp16_t       sc;
        logic [63:0] q0;
        logic [63:0] q1;
        logic        re;
        logic        typed;
        fp32_t       v0;
    } blk_row_t;

    localparam int unsigned N_RANDOM = 460;
    localparam int unsigned WATCHDOG = 2000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [15:0] scale_bits = '0;
    logic [63:0] quants_first_half = '0;
    logic [63:0] quants_second_half = '0;
    logic        row_end = 1'b0;
    logic        valid;
    logic [31:0] value_a, value_b, value_c, value_d;
    logic [2:0]  beat;
    logic        block_done, row_done;

    beat_exp_t   beats_due [$];
    fp32_t       first_value_due [$];
    int unsigned mismatches = 0;
    int unsigned idle_cycles = 0;
    logic        stimulus_done = 1'b0;

    always #1 clk = ~clk;

    q4_0_block_dequantizer_core i_dut (.*);

    function automatic fp32_t scale_code(input fp16_t h, input int n);
        logic        s;
        logic [4:0]  e;
        logic [9:0]  m;
        int          v;
        int          mag;
        logic [31:0] sig;
        int          k;
        int          p;
        logic        rs;
        s = h[15];
        e = h[14:10];
        m = h[9:0];
        v = n - int'(CODE_OFFSET);
        mag = (v < 0) ? -v : v;
        rs = s ^ (v < 0);
        if (e == 5'h1F)
        begin
            if (m != 0)
                return {s, 8'hFF, 1'b1, m[8:0], 13'h0};
            if (mag == 0)
                return DEFAULT_NAN;
            return {rs, 8'hFF, 23'h0};
        end
        if (e == 0)
        begin
            sig = {22'h0, m};
            k = -24;
        end
        else
        begin
            sig = {21'h0, 1'b1, m};
            k = int'(e) - 25;
        end
        sig = sig * mag;
        if (sig == 0)
            return {rs, 31'h0};
        p = 0;
        while (p < 31 && (sig >> (p + 1)) != 0)
            p++;
        return {rs, 8'(p + k + 127), 23'((sig << (23 - p)) & 32'h7FFFFF)};
    endfunction

    task automatic predict_block(input blk_row_t b);
        beat_exp_t   x;
        logic [7:0]  by;
        int          idx;
        for (int r = 0; r < int'(BEATS); r++)
        begin
            for (int j = 0; j < int'(LANES); j++)
            begin
                idx = r * 4 + j;
                by = (idx % 16 < 8) ? b.q0[8 * (idx % 8) +: 8] : b.q1[8 * (idx % 8) +: 8];
                x.v[j] = scale_code(b.sc, (idx >= 16) ? int'(by[7:4] & NIBBLE_MASK)
                                                       : int'(by[3:0] & NIBBLE_MASK));
            end
            x.bt = beat_t'(r);
            x.bdone = (r == 7);
            x.rdone = (r == 7) && b.re;
            beats_due.push_back(x);
        end
        if (b.typed)
            first_value_due.push_back(b.v0);
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h, expected %h", what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        if (valid)
        begin
            if (beats_due.size() == 0)
                report("unexpected result", value_a, 0);
            else
            begin
                beat_exp_t x;
                x = beats_due.pop_front();
                if (value_a !== x.v[0]) report("value_a", value_a, x.v[0]);
                if (value_b !== x.v[1]) report("value_b", value_b, x.v[1]);
                if (value_c !== x.v[2]) report("value_c", value_c, x.v[2]);
                if (value_d !== x.v[3]) report("value_d", value_d, x.v[3]);
                if (beat !== x.bt) report("beat", beat, x.bt);
                if (block_done !== x.bdone) report("block_done", block_done, x.bdone);
                if (row_done !== x.rdone) report("row_done", row_done, x.rdone);
                if (x.bt == 0 && first_value_due.size() != 0 && x.v[0] === first_value_due[0])
                    void'(first_value_due.pop_front());
                else if (x.bt == 0 && first_value_due.size() != 0)
                    report("typed value", value_a, first_value_due.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || valid || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    task automatic send_block(input blk_row_t b);
        scale_bits <= b.sc;
        quants_first_half <= b.q0;
        quants_second_half <= b.q1;
        row_end <= b.re;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_block(b);
    endtask

    task automatic pause(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    function automatic blk_row_t random_block();
        blk_row_t b;
        case ($urandom_range(0, 9))
            0: b.sc = {1'($urandom_range(0, 1)), 5'h1F, 10'($urandom)};
            1: b.sc = {1'($urandom_range(0, 1)), 5'h00, 10'($urandom)};
            default: b.sc = 16'($urandom);
        endcase
        b.q0 = {$urandom, $urandom};
        b.q1 = {$urandom, $urandom};
        b.re = 1'($urandom_range(0, 1));
        b.typed = 1'b0;
        b.v0 = '0;
        return b;
    endfunction

    blk_row_t directed [] = '{
        '{16'h3C00, 64'h0, 64'h0, 1'b0, 1'b1, 32'hC100_0000},
        '{16'h3C00, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1,
          32'h40E0_0000},
        '{16'h3C00, 64'h8888_8888_8888_8888, 64'h8888_8888_8888_8888, 1'b0, 1'b1, 32'h0},
        '{16'hBC00, 64'h8888_8888_8888_8888, 64'h0, 1'b1, 1'b1, 32'h8000_0000},
        '{16'h7C00, 64'h8, 64'hFEDC_BA98_7654_3210, 1'b0, 1'b1, DEFAULT_NAN},
        '{16'hFC00, 64'h0, 64'h0, 1'b1, 1'b1, 32'h7F80_0000},
        '{16'h7E01, 64'h1234_5678_9ABC_DEF0, 64'h0, 1'b0, 1'b1, 32'h7FC0_2000},
        '{16'hFD55, 64'h0, 64'h0, 1'b0, 1'b1, 32'hFFEA_A000},
        '{16'h0001, 64'h0, 64'h0, 1'b0, 1'b1, 32'hB500_0000},
        '{16'h83FF, 64'hF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 32'h0},
        '{16'h7BFF, 64'h7654_3210_FEDC_BA98, 64'hFEDC_BA98_7654_3210, 1'b0, 1'b0, 32'h0},
        '{16'h0000, 64'hA5A5_A5A5_5A5A_5A5A, 64'h0F0F_F0F0_1234_5678, 1'b1, 1'b0, 32'h0},
        '{16'h8000, 64'h0123_4567_89AB_CDEF, 64'h0, 1'b0, 1'b0, 32'h0},
        '{16'h0400, 64'hFFFF_FFFF_0000_0000, 64'h1111_1111_1111_1111, 1'b0, 1'b0, 32'h0}
    };

    initial
    begin
        int unsigned burst;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
        begin
            send_block(directed[i]);
            if ($urandom_range(0, 2) == 0)
                pause($urandom_range(1, 12));
        end
        pause(1);
        while (beats_due.size() != 0)
            @(posedge clk);
        for (int n = 0; n < int'(N_RANDOM);)
        begin
            burst = $urandom_range(1, 20);
            for (int k = 0; k < int'(burst) && n < int'(N_RANDOM); k++, n++)
                send_block(random_block());
            if (n == N_RANDOM / 2)
            begin
                pause(1);
                while (beats_due.size() != 0)
                    @(posedge clk);
            end
            else if ($urandom_range(0, 3) != 0)
                pause($urandom_range(1, 15));
        end
        start <= 1'b0;
        stimulus_done <= 1'b1;
    end

    initial
    begin
        wait (stimulus_done);
        while (beats_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && first_value_due.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
